### design/spike_rejecting_block_averager_defines.svh
// ---------------------------------------------------------------------------
// Spike rejecting block averager assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SPIKE_REJECTING_BLOCK_AVERAGER_DEFINES_SVH
`define SPIKE_REJECTING_BLOCK_AVERAGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/srba_pkg.sv
// ---------------------------------------------------------------------------
// srba_pkg
// Types, register codes and reset values of the spike rejecting averager.
// ---------------------------------------------------------------------------
package srba_pkg;

  // default sizing
  localparam int unsigned MAX_WINDOW_DEF  = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned WS_CFG_W   = 13;
  localparam int unsigned LIM_W      = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_NEAR   = 2'd2,
    REG_FAR    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_PICK = 1'b0,
    MODE_MEAN = 1'b1
  } mode_e;

  localparam mode_e               MODE_RST   = MODE_MEAN;
  localparam logic [WS_CFG_W-1:0] WINDOW_RST = 13'd1;
  localparam logic [LIM_W-1:0]    NEAR_RST   = 20'd3000;
  localparam logic [LIM_W-1:0]    FAR_RST    = 20'd100000;

  typedef struct packed {
    mode_e               mode;
    logic [WS_CFG_W-1:0] window;
    logic [LIM_W-1:0]    near;
    logic [LIM_W-1:0]    far;
  } srba_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic proc;       // process one sample
    logic phase;      // 0: pending sample, 1: final sample of stream
    logic last;       // last result of this beat
    logic div_start;  // start mean division
    logic emit;       // load output register
  } srba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pend_valid;
    logic eos;
    logic win_end;
    logic mean;
    logic ws_one;
    logic div_busy;
    logic div_done;
    logic out_free;
  } srba_sts_t;

endpackage

### design/srba_in_if.sv
// ---------------------------------------------------------------------------
// srba_in_if
// Sample input channel: valid/ready with sample and end-of-stream flag.
// ---------------------------------------------------------------------------
interface srba_in_if import srba_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

### design/srba_out_if.sv
// ---------------------------------------------------------------------------
// srba_out_if
// Result output channel: valid/ready with value and last-in-run flag.
// ---------------------------------------------------------------------------
interface srba_out_if import srba_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last_in_run;

  modport source (output valid, value, last_in_run, input ready);
  modport sink   (input valid, value, last_in_run, output ready);
endinterface

### design/srba_cfg_if.sv
// ---------------------------------------------------------------------------
// srba_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ---------------------------------------------------------------------------
interface srba_cfg_if import srba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/srba_div.sv
// ---------------------------------------------------------------------------
// srba_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
module srba_div import srba_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 44,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    trial;

  // one restoring step: shift in next dividend bit, try subtract
  assign rem_sh = {rem_q, quot_q[DIVIDEND_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DIVISOR_W]) begin
        rem_d  = trial[DIVISOR_W-1:0];
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[DIVISOR_W-1:0];
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = quot_q;

endmodule

### design/srba_dp.sv
// ---------------------------------------------------------------------------
// srba_dp
// Datapath: spike check, window accumulation, pick hold, divider, output reg.
// ---------------------------------------------------------------------------
module srba_dp import srba_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srba_cfg_t                     cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          eos_i,
  input  srba_cmd_t                     cmd_i,
  output srba_sts_t                     sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_value_o,
  output logic                          out_last_o
);

  localparam int unsigned WS_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned POS_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned CMP_W  = (WS_W > WS_CFG_W) ? WS_W : WS_CFG_W;
  localparam int unsigned PCMP_W = ((POS_W > WS_W) ? POS_W : WS_W) + 1;
  localparam int unsigned DIF_W  = (SAMPLE_BITS + 1 > LIM_W) ? SAMPLE_BITS + 1 : LIM_W;

  // |a - b| without overflow
  function automatic logic [DIF_W-1:0] abs_diff(logic signed [SAMPLE_BITS-1:0] a,
                                                logic signed [SAMPLE_BITS-1:0] b);
    logic signed [SAMPLE_BITS:0] d;
    logic        [SAMPLE_BITS:0] m;
    d = (SAMPLE_BITS + 1)'(a) - (SAMPLE_BITS + 1)'(b);
    m = d[SAMPLE_BITS] ? $unsigned(-d) : $unsigned(d);
    return DIF_W'(m);
  endfunction

  // stream state
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic                          eos_q;
  logic signed [SAMPLE_BITS-1:0] pend_q;
  logic                          pend_valid_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic                          started_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [POS_W-1:0]              pos_q;

  // result staging
  logic [SUM_W-1:0]              pick_q;
  logic                          res_mean_q;
  logic                          res_neg_q;
  logic                          last_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic                          out_last_q;

  logic [CMP_W-1:0]              ws_cfg_wide;
  logic [WS_W-1:0]               ws_eff;
  logic                          win_end;
  logic                          pick_hit;
  logic signed [SAMPLE_BITS-1:0] cur_x;
  logic [DIF_W-1:0]              d_prev;
  logic [DIF_W-1:0]              d_next;
  logic [DIF_W-1:0]              near_w;
  logic [DIF_W-1:0]              far_w;
  logic                          spike;
  logic signed [SAMPLE_BITS-1:0] kept;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              sum_mag;
  logic                          out_free;
  logic                          div_busy;
  logic                          div_done;
  logic [SUM_W-1:0]              div_quot;
  logic [SUM_W-1:0]              res_mag;
  logic [SUM_W-1:0]              res_val;

  // effective window: zero acts as one, clamp to MAX_WINDOW
  assign ws_cfg_wide = CMP_W'(cfg_i.window);
  always_comb begin
    priority if (ws_cfg_wide == '0) begin
      ws_eff = WS_W'(1);
    end else if (ws_cfg_wide > CMP_W'(MAX_WINDOW)) begin
      ws_eff = WS_W'(MAX_WINDOW);
    end else begin
      ws_eff = ws_cfg_wide[WS_W-1:0];
    end
  end

  assign win_end  = (PCMP_W'(pos_q) + PCMP_W'(1)) >= PCMP_W'(ws_eff);
  assign pick_hit = PCMP_W'(pos_q) == PCMP_W'(ws_eff >> 1);

  // spike check on the sample being processed
  assign cur_x  = cmd_i.phase ? cur_q : pend_q;
  assign d_prev = abs_diff(cur_x, prev_q);
  assign d_next = abs_diff(cur_x, cur_q);
  assign near_w = DIF_W'(cfg_i.near);
  assign far_w  = DIF_W'(cfg_i.far);
  assign spike  = (cfg_i.mode == MODE_MEAN) && started_q &&
                  (((d_prev > near_w) && (d_next > near_w)) || (d_prev > far_w));
  assign kept   = spike ? prev_q : cur_x;

  // accumulate in mean mode, hold picked sample in pick mode
  always_comb begin
    if (cfg_i.mode == MODE_MEAN) begin
      sum_next = sum_q + SUM_W'(kept);
    end else if (pick_hit) begin
      sum_next = SUM_W'(cur_x);
    end else begin
      sum_next = sum_q;
    end
  end

  assign sum_mag = sum_next[SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);

  // mean division
  srba_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (WS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_mag),
    .divisor_i  (ws_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // stream state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      prev_q       <= '0;
      started_q    <= 1'b0;
      sum_q        <= '0;
      pos_q        <= '0;
    end else begin
      if (cmd_i.load && !pend_valid_q) begin
        pend_q       <= sample_i;
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.proc) begin
        if (cmd_i.phase) begin
          // final sample of the stream: drop partial window, restart
          pend_q       <= '0;
          pend_valid_q <= 1'b0;
          prev_q       <= '0;
          started_q    <= 1'b0;
          sum_q        <= '0;
          pos_q        <= '0;
        end else begin
          pend_q    <= cur_q;
          prev_q    <= kept;
          started_q <= 1'b1;
          if (win_end) begin
            sum_q <= '0;
            pos_q <= '0;
          end else begin
            sum_q <= sum_next;
            pos_q <= pos_q + POS_W'(1);
          end
        end
      end
    end
  end

  // input capture and result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= sample_i;
      eos_q <= eos_i;
    end
    if (cmd_i.proc && win_end) begin
      last_q     <= cmd_i.last;
      res_mean_q <= (cfg_i.mode == MODE_MEAN);
      res_neg_q  <= (cfg_i.mode == MODE_MEAN) && sum_next[SUM_W-1];
      pick_q     <= $unsigned(sum_next);
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign res_mag  = res_mean_q ? div_quot : pick_q;
  assign res_val  = res_neg_q ? (~res_mag + SUM_W'(1)) : res_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= $signed(res_val[SAMPLE_BITS-1:0]);
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // status
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.eos        = eos_q;
  assign sts_o.win_end    = win_end;
  assign sts_o.mean       = (cfg_i.mode == MODE_MEAN);
  assign sts_o.ws_one     = (ws_eff == WS_W'(1));
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;

endmodule

### design/srba_ctrl.sv
// ---------------------------------------------------------------------------
// srba_ctrl
// Controller: sequences capture, one or two processing steps, division, emit.
// ---------------------------------------------------------------------------
module srba_ctrl import srba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_eos_i,
  output logic      in_ready_o,
  input  srba_sts_t sts_i,
  output srba_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PROC = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.phase = phase_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.pend_valid) begin
            phase_d = 1'b0;
            state_d = S_PROC;
          end else if (in_eos_i) begin
            phase_d = 1'b1;
            state_d = S_PROC;
          end
        end
      end
      S_PROC: begin
        cmd_o.proc = 1'b1;
        // a second result follows only at end of stream with a window of one
        cmd_o.last = phase_q || !sts_i.eos || !sts_i.ws_one;
        if (sts_i.win_end) begin
          if (sts_i.mean) begin
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end else begin
            state_d = S_EMIT;
          end
        end else if (!phase_q && sts_i.eos) begin
          phase_d = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!phase_q && sts_i.eos) begin
            phase_d = 1'b1;
            state_d = S_PROC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

### design/spike_rejecting_block_averager.sv
// ---------------------------------------------------------------------------
// spike_rejecting_block_averager
// Decimating boxcar average of a sample stream with spike rejection.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : one sample per beat, end_of_stream marks the last of a stream.
//   out_if : window mean (mode 1) or middle sample of the window (mode 0);
//            last_in_run flags the final result caused by one input beat.
//   cfg_if : register writes (0 mode, 1 window_size, 2 near_limit,
//            3 far_limit), always ready; write only while the block is idle.
// A sample is processed when the next one arrives (one-sample lookahead);
// end_of_stream processes both and may yield two results, then drops any
// partial window. The first sample of a stream is only captured unless it
// also ends the stream; any other beat is captured and processed, a closing
// pick window adds an emit step, and a closing mean window adds a division
// by the serial divider, one quotient bit per cycle, before the emit; an
// end-of-stream beat may take two such passes. Reset loads the register
// defaults and clears the stream state; no clearing pass. A finished result
// waits in the output register while the next beat is taken; if the
// receiver stalls and another result is due, processing holds until the
// register frees up.
// ---------------------------------------------------------------------------
`include "spike_rejecting_block_averager_defines.svh"

module spike_rejecting_block_averager import srba_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srba_in_if.sink     in_if,
  srba_out_if.source  out_if,
  srba_cfg_if.sink    cfg_if
);

  srba_cfg_t cfg_q;
  srba_cmd_t cmd;
  srba_sts_t sts;
  logic      in_ready;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_RST;
      cfg_q.window <= WINDOW_RST;
      cfg_q.near   <= NEAR_RST;
      cfg_q.far    <= FAR_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_reg_e'(cfg_if.index))
        REG_MODE:   cfg_q.mode   <= mode_e'(cfg_if.data[0]);
        REG_WINDOW: cfg_q.window <= cfg_if.data[WS_CFG_W-1:0];
        REG_NEAR:   cfg_q.near   <= cfg_if.data[LIM_W-1:0];
        REG_FAR:    cfg_q.far    <= cfg_if.data[LIM_W-1:0];
      endcase
    end
  end

  // controller
  srba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_eos_i   (in_if.end_of_stream),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_if.ready = in_ready;

  // datapath
  srba_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sample_i    (in_if.sample),
    .eos_i       (in_if.end_of_stream),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_value_o (out_if.value),
    .out_last_o  (out_if.last_in_run)
  );

  // checks
  `SRBA_ASSERT_NOW(a_no_beat_in_div, in_if.valid && in_if.ready, !sts.div_busy, "beat taken during division")
  `SRBA_ASSERT_NOW(a_no_proc_in_div, cmd.proc, !sts.div_busy, "sample processed during division")
  `SRBA_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "result overwrites unread output")
  `SRBA_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")

endmodule

### test/srba_result_check.sv
// ---------------------------------------------------------------------------
// srba_result_check
// Watches the sample, result and register channels of the averager. It keeps
// its own copy of the settings and stream state, works out the window results
// that each accepted sample beat causes, and compares every result beat field
// by field with the oldest one outstanding.
// ---------------------------------------------------------------------------
module srba_result_check import srba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  srba_in_if   in_mon,
  srba_out_if  out_mon,
  srba_cfg_if  cfg_mon,
  output int   err_cnt_o,
  output int   pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [SAMPLE_BITS_DEF-1:0] value;
    logic                              last_in_run;
  } window_result_t;

  // results still owed by the block, oldest first
  window_result_t window_results_q[$];

  // register copy
  mode_e               mode_r;
  logic [WS_CFG_W-1:0] window_r;
  logic [LIM_W-1:0]    near_r;
  logic [LIM_W-1:0]    far_r;

  // stream state
  logic signed [SAMPLE_BITS_DEF-1:0] kept_prev;
  logic signed [SAMPLE_BITS_DEF-1:0] held_sample;
  logic                              held_valid;
  logic                              stream_started;
  longint                            win_acc;
  logic [11:0]                       win_pos;

  int err_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_total++;
  endtask

  function automatic longint abs_diff(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic clear_stream();
    kept_prev      = '0;
    held_sample    = '0;
    held_valid     = 1'b0;
    stream_started = 1'b0;
    win_acc        = 0;
    win_pos        = '0;
  endtask

  // one sample through spike filter and window; queues a result on window end
  task automatic process_sample(input longint x, input longint nxt);
    int             ws;
    longint         kept;
    longint         dp;
    longint         dn;
    longint         avg;
    window_result_t res;
    ws = int'(window_r);
    if (ws == 0) ws = 1;
    if (ws > int'(MAX_WINDOW_DEF)) ws = int'(MAX_WINDOW_DEF);
    kept = x;
    if (mode_r == MODE_MEAN && stream_started) begin
      dp = abs_diff(x, kept_prev);
      dn = abs_diff(x, nxt);
      // spike against both neighbors, or a jump too far from the last kept one
      if ((dp > longint'(near_r) && dn > longint'(near_r)) || dp > longint'(far_r)) begin
        kept = kept_prev;
      end
    end
    stream_started = 1'b1;
    kept_prev      = kept[SAMPLE_BITS_DEF-1:0];
    if (mode_r == MODE_MEAN) begin
      win_acc += kept;
    end else if (int'(win_pos) == ws / 2) begin
      win_acc = x;
    end
    if (int'(win_pos) + 1 >= ws) begin
      // mean truncates toward zero; pick passes the held value as it stands
      avg             = (mode_r == MODE_MEAN) ? win_acc / longint'(ws) : win_acc;
      res.value       = avg[SAMPLE_BITS_DEF-1:0];
      res.last_in_run = 1'b0;
      window_results_q.push_back(res);
      win_acc = 0;
      win_pos = '0;
    end else begin
      win_pos = win_pos + 12'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int             n_before;
    window_result_t want;
    if (!rst_ni) begin
      mode_r   = MODE_RST;
      window_r = WINDOW_RST;
      near_r   = NEAR_RST;
      far_r    = FAR_RST;
      clear_stream();
      window_results_q.delete();
      err_total  = 0;
      err_cnt_o  <= 0;
      pend_cnt_o <= 0;
    end else begin
      // register write beat
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_MODE:   mode_r   = mode_e'(cfg_mon.data[0]);
          REG_WINDOW: window_r = cfg_mon.data[WS_CFG_W-1:0];
          REG_NEAR:   near_r   = cfg_mon.data[LIM_W-1:0];
          REG_FAR:    far_r    = cfg_mon.data[LIM_W-1:0];
          default: ;
        endcase
      end

      // sample beat: pending sample gets its lookahead, final sample uses itself
      if (in_mon.valid && in_mon.ready) begin
        n_before = window_results_q.size();
        if (held_valid) process_sample(held_sample, in_mon.sample);
        held_sample = in_mon.sample;
        held_valid  = 1'b1;
        if (in_mon.end_of_stream) begin
          process_sample(in_mon.sample, in_mon.sample);
          clear_stream();
        end
        if (window_results_q.size() > n_before) begin
          window_results_q[window_results_q.size()-1].last_in_run = 1'b1;
        end
      end

      // result beat
      if (out_mon.valid && out_mon.ready) begin
        if (window_results_q.size() == 0) begin
          report_mismatch($sformatf("result value %0d with nothing outstanding",
                                    out_mon.value));
        end else begin
          want = window_results_q.pop_front();
          if (out_mon.value !== want.value) begin
            report_mismatch($sformatf("value got %0d want %0d", out_mon.value, want.value));
          end
          if (out_mon.last_in_run !== want.last_in_run) begin
            report_mismatch($sformatf("last_in_run got %b want %b (value %0d)",
                                      out_mon.last_in_run, want.last_in_run, want.value));
          end
        end
      end

      pend_cnt_o <= window_results_q.size();
      err_cnt_o  <= err_total;
    end
  end

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives the averager with directed spike, extreme and window cases, then
// random phases of smooth streams with spikes and jumps plus noise, under
// random idling on both sides, a long result hold-off, a clamped top window
// code and a long window.
// Checking is done by srba_result_check; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top import srba_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 900;

  logic clk;
  logic rst_n;
  int   err_cnt;
  int   pend_cnt;
  bit   hold_off_req;
  int   send_calm;

  // settings as last written, used to shape the stimulus
  int win_set;
  int near_set;
  int far_set;

  srba_in_if  in_ch ();
  srba_out_if out_ch ();
  srba_cfg_if cfg_ch ();

  spike_rejecting_block_averager u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  srba_result_check u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // random idle gap before a beat, with occasional stretches of none
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int eff_window();
    if (win_set == 0) return 1;
    if (win_set > int'(MAX_WINDOW_DEF)) return int'(MAX_WINDOW_DEF);
    return win_set;
  endfunction

  function automatic longint rand_sign();
    return $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
  endfunction

  // one sample beat; valid stays high across back-to-back beats
  task automatic send_beat(input logic signed [31:0] s, input logic e);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= s;
    in_ch.end_of_stream <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WINDOW: win_set  = int'(d[WS_CFG_W-1:0]);
      REG_NEAR:   near_set = int'(d[LIM_W-1:0]);
      REG_FAR:    far_set  = int'(d[LIM_W-1:0]);
      default: ;
    endcase
  endtask

  // sender pause until every outstanding result is out and the block is quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // smooth random walk with spikes, threshold hits and far jumps, closed by eos
  task automatic send_stream(input int len);
    longint cur;
    longint x;
    longint spread;
    int     pick;
    int     i;
    cur    = longint'($signed($urandom()));
    spread = longint'(near_set / 4) + 1;
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        x = cur + longint'($urandom_range(0, 32'(2 * spread))) - spread;
      end else if (pick < 86) begin
        x = cur + rand_sign() * (longint'(near_set) + 1 + longint'($urandom_range(0, near_set)));
      end else if (pick < 90) begin
        cur = cur + rand_sign() * (longint'(far_set) + 1 + longint'($urandom_range(0, 1000)));
        x   = cur;
      end else if (pick < 95) begin
        x = cur + rand_sign() * longint'(near_set);
      end else begin
        x = longint'($signed($urandom()));
      end
      send_beat(sat32(x), i == len - 1);
      cur = sat32(cur + longint'($urandom_range(0, 32'(spread))) - spread / 2);
    end
  endtask

  task automatic send_noise(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_beat($urandom(), $urandom_range(0, 3) == 0);
    end
  endtask

  // rewrite a random subset of the registers, extremes included
  task automatic random_config();
    logic [3:0] sel_mask;
    int         sel;
    sel_mask = 4'($urandom_range(1, 15));
    if (sel_mask[0]) begin
      if ($urandom_range(0, 3) == 0) write_reg(REG_MODE, 20'($urandom()));
      else write_reg(REG_MODE, 20'($urandom_range(0, 1)));
    end
    if (sel_mask[1]) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       write_reg(REG_WINDOW, 20'd0);
        1:       write_reg(REG_WINDOW, 20'd8191);
        2:       write_reg(REG_WINDOW, 20'(MAX_WINDOW_DEF));
        3:       write_reg(REG_WINDOW, {7'($urandom()), 13'($urandom_range(1, 6))});
        default: write_reg(REG_WINDOW, 20'($urandom_range(1, (sel < 14) ? 4 : 16)));
      endcase
    end
    if (sel_mask[2]) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       write_reg(REG_NEAR, 20'd0);
        1:       write_reg(REG_NEAR, 20'hFFFFF);
        2, 3:    write_reg(REG_NEAR, 20'($urandom()));
        default: write_reg(REG_NEAR, 20'($urandom_range(0, 5000)));
      endcase
    end
    if (sel_mask[3]) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       write_reg(REG_FAR, 20'd0);
        1:       write_reg(REG_FAR, 20'hFFFFF);
        2:       write_reg(REG_FAR, 20'($urandom()));
        default: write_reg(REG_FAR, 20'($urandom_range(1000, 200000)));
      endcase
    end
  endtask

  // result side: random stalls per beat, plus a long hold-off on request
  initial begin
    int stall;
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = draw_wait(calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // run limit
  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int rand_items;
    int sent;
    int len;
    int phase_len;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.sample        <= '0;
    in_ch.end_of_stream <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_MODE;
    cfg_ch.data         <= '0;
    win_set      = int'(WINDOW_RST);
    near_set     = int'(NEAR_RST);
    far_set      = int'(FAR_RST);
    hold_off_req = 1'b0;
    send_calm    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: mean of one; first kept, two-sided spike, threshold
    // equality, a real step, far jumps, and eos with a pending sample
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd5000, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd3000, 1'b0);
    send_beat(32'sd6500, 1'b0);
    send_beat(32'sd6400, 1'b0);
    send_beat(32'sd106401, 1'b0);
    send_beat(32'sd106401, 1'b0);
    send_beat(32'sd106401, 1'b1);
    // full-scale extremes
    send_beat(32'sh7fffffff, 1'b0);
    send_beat(32'sh80000000, 1'b1);
    // stream of a single sample
    send_beat(-32'sd1, 1'b1);
    drain_results();

    // zero limits: any change is rejected
    write_reg(REG_NEAR, 20'd0);
    write_reg(REG_FAR, 20'd0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd6, 1'b1);
    drain_results();

    // pick mode, window of three; partial window dropped at eos
    write_reg(REG_MODE, 20'(MODE_PICK));
    write_reg(REG_WINDOW, 20'd3);
    send_beat(32'sd10, 1'b0);
    send_beat(32'sd20, 1'b0);
    send_beat(32'sd30, 1'b0);
    send_beat(32'sd40, 1'b0);
    send_beat(32'sd50, 1'b1);
    drain_results();

    // window zero behaves as one, limits at maximum
    write_reg(REG_MODE, 20'(MODE_MEAN));
    write_reg(REG_WINDOW, 20'd0);
    write_reg(REG_NEAR, 20'hFFFFF);
    write_reg(REG_FAR, 20'hFFFFF);
    send_beat(-32'sd7, 1'b0);
    send_beat(32'sd8, 1'b1);
    drain_results();

    // negative means truncate toward zero
    write_reg(REG_WINDOW, 20'd2);
    send_beat(32'sd3, 1'b0);
    send_beat(-32'sd4, 1'b0);
    send_beat(-32'sd3, 1'b0);
    send_beat(-32'sd4, 1'b1);
    drain_results();

    // result side held off while samples keep coming: input must stall
    write_reg(REG_MODE, 20'(MODE_PICK));
    write_reg(REG_WINDOW, 20'd1);
    hold_off_req = 1'b1;
    send_stream(40);
    drain_results();

    // top window code clamps to MAX_WINDOW: a short stream closes no window
    write_reg(REG_MODE, 20'(MODE_MEAN));
    write_reg(REG_WINDOW, 20'd8191);
    write_reg(REG_NEAR, 20'hFFFFF);
    write_reg(REG_FAR, 20'hFFFFF);
    send_stream(100);
    drain_results();

    // long window closed once, partial tail dropped
    write_reg(REG_WINDOW, 20'd500);
    send_stream(501);

    // random phases
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      drain_results();
      random_config();
      phase_len = $urandom_range(40, 160);
      sent      = 0;
      while (sent < phase_len) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(1, 3 * eff_window() + 6);
          if (len > 64) len = $urandom_range(1, 64);
          send_stream(len);
        end else begin
          len = $urandom_range(1, 6);
          send_noise(len);
        end
        sent += len;
      end
      rand_items += sent;
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
